>>> hw/rtl/rasp_pkg.sv
// ----------------------------------------------------------------------------
// rasp_pkg: shared types and constants of the RESP array stream parser
// Byte classes, event and error codes, payload structs and limit helpers.
// ----------------------------------------------------------------------------
package rasp_pkg;

	// counter widths
	localparam int COUNT_BITS  = 16;
	localparam int LENGTH_BITS = 32;
	localparam int ACC_BITS    = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
	localparam int PROD_BITS   = ACC_BITS + 4;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// configuration port
	localparam int MAX_COUNT_W    = 16;
	localparam int MAX_LENGTH_W   = 30;
	localparam int CFG_DATA_BITS  = 30;
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_COUNT  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LENGTH = 1'd1;
	localparam logic [MAX_COUNT_W-1:0]    MAX_COUNT_RST  = 16'd1024;
	localparam logic [MAX_LENGTH_W-1:0]   MAX_LENGTH_RST = 30'd536870912;

	// largest values the counters can hold
	localparam logic [32:0] CNT_CAP = (33'd1 << COUNT_BITS) - 33'd1;
	localparam logic [32:0] LEN_CAP = (33'd1 << LENGTH_BITS) - 33'd1;

	// protocol characters
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// byte classes
	localparam logic [2:0] CLS_OTHER  = 3'd0;
	localparam logic [2:0] CLS_DIGIT  = 3'd1;
	localparam logic [2:0] CLS_CR     = 3'd2;
	localparam logic [2:0] CLS_LF     = 3'd3;
	localparam logic [2:0] CLS_STAR   = 3'd4;
	localparam logic [2:0] CLS_DOLLAR = 3'd5;

	// result events
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PAYLOAD = 2'd1;
	localparam logic [1:0] EV_DONE    = 2'd2;
	localparam logic [1:0] EV_ERROR   = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_NOT_ARRAY   = 3'd1;
	localparam logic [2:0] ERR_EXP_BULK    = 3'd2;
	localparam logic [2:0] ERR_BAD_NUMBER  = 3'd3;
	localparam logic [2:0] ERR_TOO_LARGE   = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  payload_byte;
		logic [15:0] element_index;
		logic        last_of_element;
		logic [15:0] element_total;
		logic [2:0]  fault_code;
	} out_item_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] byte_val;
		logic [3:0] digit;
		logic [2:0] cls;
		logic       eob;
	} token_t;

	// effective limits, already clipped to the counter widths
	typedef struct packed {
		logic [COUNT_BITS-1:0]  cnt_lim;
		logic [LENGTH_BITS-1:0] len_lim;
	} limits_t;

	function automatic logic [COUNT_BITS-1:0] count_limit(input logic [MAX_COUNT_W-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		if (w > CNT_CAP)
			w = CNT_CAP;
		return w[COUNT_BITS-1:0];
	endfunction

	function automatic logic [LENGTH_BITS-1:0] length_limit(input logic [MAX_LENGTH_W-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		if (w > LEN_CAP)
			w = LEN_CAP;
		return w[LENGTH_BITS-1:0];
	endfunction

endpackage

>>> hw/rtl/rasp_front.sv
// ----------------------------------------------------------------------------
// rasp_front: input stage of the RESP parser
// Classifies one byte per cycle unless stalled and holds it for the queue.
// ----------------------------------------------------------------------------
module rasp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rasp_pkg::in_item_t in_data,
	output logic               tok_valid,
	input  logic               tok_full,
	output rasp_pkg::token_t   tok_data
);

	logic             valid_s1;
	rasp_pkg::token_t tok_s1;
	rasp_pkg::token_t tok_c;
	logic             accept;

	// byte classifier
	always_comb begin
		tok_c.byte_val = in_data.in_byte;
		tok_c.eob      = in_data.end_of_buffer;
		tok_c.digit    = 4'(in_data.in_byte - rasp_pkg::CH_ZERO);
		if (in_data.in_byte >= rasp_pkg::CH_ZERO && in_data.in_byte <= rasp_pkg::CH_NINE)
			tok_c.cls = rasp_pkg::CLS_DIGIT;
		else if (in_data.in_byte == rasp_pkg::CH_CR)
			tok_c.cls = rasp_pkg::CLS_CR;
		else if (in_data.in_byte == rasp_pkg::CH_LF)
			tok_c.cls = rasp_pkg::CLS_LF;
		else if (in_data.in_byte == rasp_pkg::CH_STAR)
			tok_c.cls = rasp_pkg::CLS_STAR;
		else if (in_data.in_byte == rasp_pkg::CH_DOLLAR)
			tok_c.cls = rasp_pkg::CLS_DOLLAR;
		else
			tok_c.cls = rasp_pkg::CLS_OTHER;
	end

	// stage register, refilled in the cycle it drains
	assign in_stall = valid_s1 && tok_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!tok_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1 <= tok_c;
		end
	end

	assign tok_valid = valid_s1;
	assign tok_data  = tok_s1;

endmodule

>>> hw/rtl/rasp_queue.sv
// ----------------------------------------------------------------------------
// rasp_queue: short token queue
// Decouples the classifier from the parse engine so each side stalls alone.
// ----------------------------------------------------------------------------
module rasp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             full,
	input  rasp_pkg::token_t push_data,
	output logic             pop_valid,
	input  logic             pop,
	output rasp_pkg::token_t pop_data
);

	rasp_pkg::token_t               mem_q [rasp_pkg::QUEUE_DEPTH];
	logic [rasp_pkg::QPTR_BITS-1:0] wptr_q;
	logic [rasp_pkg::QPTR_BITS-1:0] rptr_q;
	logic [rasp_pkg::QPTR_BITS:0]   count_q;
	logic                           push;

	assign full      = (count_q == (rasp_pkg::QPTR_BITS+1)'(rasp_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push      = push_valid && !full;
	assign pop_data  = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

>>> hw/rtl/rasp_back.sv
// ----------------------------------------------------------------------------
// rasp_back: parse engine of the RESP parser
// Walks the array header, bulk headers, payload and trailers one token per
// cycle unless out_stall holds it, registering one result beat per token.
// ----------------------------------------------------------------------------
module rasp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rasp_pkg::limits_t   limits,
	input  logic                q_valid,
	output logic                pop,
	input  rasp_pkg::token_t    q_item,
	output logic                out_valid,
	input  logic                out_stall,
	output rasp_pkg::out_item_t out_data
);

	localparam logic [3:0] PH_STAR    = 4'd0;
	localparam logic [3:0] PH_CNT_NUM = 4'd1;
	localparam logic [3:0] PH_CNT_LF  = 4'd2;
	localparam logic [3:0] PH_DOLLAR  = 4'd3;
	localparam logic [3:0] PH_LEN_NUM = 4'd4;
	localparam logic [3:0] PH_LEN_LF  = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_TRAIL1  = 4'd7;
	localparam logic [3:0] PH_TRAIL2  = 4'd8;
	localparam logic [3:0] PH_DRAIN   = 4'd9;

	logic [3:0]                       phase_q, phase_d;
	logic [rasp_pkg::ACC_BITS-1:0]    acc_q, acc_d;
	logic                             seen_q, seen_d;
	logic [rasp_pkg::COUNT_BITS-1:0]  erem_q, erem_d;
	logic [rasp_pkg::COUNT_BITS-1:0]  cur_q, cur_d;
	logic [rasp_pkg::COUNT_BITS-1:0]  decl_q, decl_d;
	logic [rasp_pkg::LENGTH_BITS-1:0] prem_q, prem_d;
	logic [rasp_pkg::ACC_BITS-1:0]    lim;
	logic [rasp_pkg::PROD_BITS-1:0]   prod;
	logic                             over;
	rasp_pkg::out_item_t              res;
	rasp_pkg::out_item_t              out_q;
	logic                             out_valid_q;

	assign pop = q_valid && (!out_valid_q || !out_stall);

	// decimal digit step: acc * 10 + digit against the active limit
	always_comb begin
		lim  = (phase_q == PH_CNT_NUM) ? rasp_pkg::ACC_BITS'(limits.cnt_lim)
		                               : rasp_pkg::ACC_BITS'(limits.len_lim);
		prod = (rasp_pkg::PROD_BITS'(acc_q) << 3) + (rasp_pkg::PROD_BITS'(acc_q) << 1)
		     + rasp_pkg::PROD_BITS'(q_item.digit);
		over = prod > rasp_pkg::PROD_BITS'(lim);
	end

	// next state and result of one token
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		seen_d  = seen_q;
		erem_d  = erem_q;
		cur_d   = cur_q;
		decl_d  = decl_q;
		prem_d  = prem_q;
		res     = '0;
		unique case (phase_q) inside
			PH_STAR: begin
				if (q_item.cls == rasp_pkg::CLS_STAR) begin
					phase_d = PH_CNT_NUM;
					acc_d   = '0;
					seen_d  = 1'b0;
				end else begin
					res.event_res  = rasp_pkg::EV_ERROR;
					res.fault_code = rasp_pkg::ERR_NOT_ARRAY;
					phase_d        = PH_DRAIN;
				end
			end
			PH_CNT_NUM, PH_LEN_NUM: begin
				if (q_item.cls == rasp_pkg::CLS_CR && seen_q) begin
					phase_d = (phase_q == PH_CNT_NUM) ? PH_CNT_LF : PH_LEN_LF;
				end else if (q_item.cls == rasp_pkg::CLS_DIGIT) begin
					acc_d  = prod[rasp_pkg::ACC_BITS-1:0];
					seen_d = 1'b1;
					if (over) begin
						res.event_res  = rasp_pkg::EV_ERROR;
						res.fault_code = rasp_pkg::ERR_TOO_LARGE;
						phase_d        = PH_DRAIN;
					end
				end else begin
					res.event_res  = rasp_pkg::EV_ERROR;
					res.fault_code = rasp_pkg::ERR_BAD_NUMBER;
					phase_d        = PH_DRAIN;
				end
			end
			PH_CNT_LF: begin
				if (q_item.cls != rasp_pkg::CLS_LF) begin
					res.event_res  = rasp_pkg::EV_ERROR;
					res.fault_code = rasp_pkg::ERR_BAD_NUMBER;
					phase_d        = PH_DRAIN;
				end else begin
					decl_d = acc_q[rasp_pkg::COUNT_BITS-1:0];
					erem_d = acc_q[rasp_pkg::COUNT_BITS-1:0];
					cur_d  = '0;
					if (acc_q[rasp_pkg::COUNT_BITS-1:0] == '0) begin
						res.event_res = rasp_pkg::EV_DONE;
						phase_d       = PH_DRAIN;
					end else begin
						phase_d = PH_DOLLAR;
					end
				end
			end
			PH_DOLLAR: begin
				if (q_item.cls == rasp_pkg::CLS_DOLLAR) begin
					phase_d = PH_LEN_NUM;
					acc_d   = '0;
					seen_d  = 1'b0;
				end else begin
					res.event_res  = rasp_pkg::EV_ERROR;
					res.fault_code = rasp_pkg::ERR_EXP_BULK;
					phase_d        = PH_DRAIN;
				end
			end
			PH_LEN_LF: begin
				if (q_item.cls != rasp_pkg::CLS_LF) begin
					res.event_res  = rasp_pkg::EV_ERROR;
					res.fault_code = rasp_pkg::ERR_BAD_NUMBER;
					phase_d        = PH_DRAIN;
				end else begin
					prem_d  = acc_q[rasp_pkg::LENGTH_BITS-1:0];
					phase_d = (acc_q[rasp_pkg::LENGTH_BITS-1:0] == '0) ? PH_TRAIL1 : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res.event_res       = rasp_pkg::EV_PAYLOAD;
				res.payload_byte    = q_item.byte_val;
				res.element_index   = 16'(cur_q);
				res.last_of_element = (prem_q == rasp_pkg::LENGTH_BITS'(1));
				prem_d              = prem_q - 1'b1;
				if (prem_q == rasp_pkg::LENGTH_BITS'(1))
					phase_d = PH_TRAIL1;
			end
			PH_TRAIL1: begin
				phase_d = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				erem_d = erem_q - 1'b1;
				cur_d  = cur_q + 1'b1;
				if (erem_q == rasp_pkg::COUNT_BITS'(1)) begin
					res.event_res     = rasp_pkg::EV_DONE;
					res.element_total = 16'(decl_q);
					phase_d           = PH_DRAIN;
				end else begin
					phase_d = PH_DOLLAR;
				end
			end
			PH_DRAIN: begin
				phase_d = PH_DRAIN;
			end
			default: begin
				phase_d = PH_DRAIN;
			end
		endcase

		// end of buffer: flag an unfinished parse, then re-arm
		if (q_item.eob) begin
			if (res.event_res != rasp_pkg::EV_DONE && res.event_res != rasp_pkg::EV_ERROR
			    && phase_d != PH_DRAIN) begin
				res            = '0;
				res.event_res  = rasp_pkg::EV_ERROR;
				res.fault_code = rasp_pkg::ERR_TRUNCATED;
			end
			phase_d = PH_STAR;
			acc_d   = '0;
			seen_d  = 1'b0;
			erem_d  = '0;
			cur_d   = '0;
			decl_d  = '0;
			prem_d  = '0;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAR;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			erem_q  <= '0;
			cur_q   <= '0;
			decl_q  <= '0;
			prem_q  <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
			erem_q  <= erem_d;
			cur_q   <= cur_d;
			decl_q  <= decl_d;
			prem_q  <= prem_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// payload phase always has bytes left
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (prem_q != '0))
		else $error("payload phase with no bytes left");

	// trailer end always has an element left to close
	a_elem_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRAIL2) |-> (erem_q != '0))
		else $error("trailer with no element left");

	// end of buffer re-arms the engine
	a_eob_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_item.eob) |=> (phase_q == PH_STAR && cur_q == '0 && erem_q == '0))
		else $error("end of buffer did not re-arm");

	// a payload beat matches the element in progress
	a_payload_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.event_res == rasp_pkg::EV_PAYLOAD)
		|-> (out_q.element_index == 16'(cur_q)
		     && (phase_q == PH_PAYLOAD || phase_q == PH_TRAIL1)))
		else $error("payload beat does not match element state");

endmodule

>>> hw/rtl/resp_array_stream_parser.sv
// ----------------------------------------------------------------------------
// resp_array_stream_parser: streaming parser for RESP arrays of bulk strings
// Classifier front, token queue and parse engine with a registered result.
// ----------------------------------------------------------------------------
// Takes one request byte per beat and returns exactly one result beat per
// byte: nothing, a payload byte with its element index and last mark, done
// with the element count, or an error code. Sustained rate is one byte per
// cycle unless the output stalls, set by the state update of the parse
// engine; a byte's result passes the classifier register, the queue, then
// the result register. The queue holds four bytes, so an output stall
// reaches the input only once the queue is full and the classifier register
// holds a byte. The user must write the two limit registers through
// cfg_wen/cfg_index/cfg_data only while idle; the block does not enforce it.
module resp_array_stream_parser (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  rasp_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output rasp_pkg::out_item_t                   out_data,
	input  logic                                  cfg_wen,
	input  logic [rasp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rasp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	rasp_pkg::limits_t limits_q;
	logic              tok_valid;
	logic              tok_full;
	rasp_pkg::token_t  tok_data;
	logic              q_valid;
	logic              q_pop;
	rasp_pkg::token_t  q_item;

	// limit registers, stored already clipped to the counter widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.cnt_lim <= rasp_pkg::count_limit(rasp_pkg::MAX_COUNT_RST);
			limits_q.len_lim <= rasp_pkg::length_limit(rasp_pkg::MAX_LENGTH_RST);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				rasp_pkg::CFG_MAX_COUNT:
					limits_q.cnt_lim <= rasp_pkg::count_limit(
						cfg_data[rasp_pkg::MAX_COUNT_W-1:0]);
				rasp_pkg::CFG_MAX_LENGTH:
					limits_q.len_lim <= rasp_pkg::length_limit(
						cfg_data[rasp_pkg::MAX_LENGTH_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	rasp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.tok_valid (tok_valid),
		.tok_full  (tok_full),
		.tok_data  (tok_data)
	);

	rasp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (tok_valid),
		.full       (tok_full),
		.push_data  (tok_data),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_item)
	);

	rasp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limits    (limits_q),
		.q_valid   (q_valid),
		.pop       (q_pop),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RESP array stream parser
// A short table of hand-picked bytes runs first. Then come random requests,
// mostly well formed and some damaged, under several limit settings. Every
// byte beat is predicted by an in-bench parser and each result beat is checked
// field by field, in order, while both sides idle and stall at random outside the widest-limit phase.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned IDLE_PCT       = 31;
	localparam int unsigned PHASE_ITEMS    = 205;
	localparam int unsigned HOLDOFF_CYCLES = 150;
	localparam int unsigned QUIET_LIMIT    = 2000;
	localparam int unsigned SETTLE_CYCLES  = 10;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// results that can be read straight off the protocol
	localparam rasp_pkg::out_item_t R_NONE       = '0;
	localparam rasp_pkg::out_item_t R_DONE_EMPTY =
		'{rasp_pkg::EV_DONE, 8'd0, 16'd0, 1'b0, 16'd0, rasp_pkg::ERR_NONE};
	localparam rasp_pkg::out_item_t R_NOT_ARRAY  =
		'{rasp_pkg::EV_ERROR, 8'd0, 16'd0, 1'b0, 16'd0, rasp_pkg::ERR_NOT_ARRAY};
	localparam rasp_pkg::out_item_t R_BAD_NUMBER =
		'{rasp_pkg::EV_ERROR, 8'd0, 16'd0, 1'b0, 16'd0, rasp_pkg::ERR_BAD_NUMBER};
	localparam rasp_pkg::out_item_t R_TOO_LARGE  =
		'{rasp_pkg::EV_ERROR, 8'd0, 16'd0, 1'b0, 16'd0, rasp_pkg::ERR_TOO_LARGE};
	localparam rasp_pkg::out_item_t R_TRUNCATED  =
		'{rasp_pkg::EV_ERROR, 8'd0, 16'd0, 1'b0, 16'd0, rasp_pkg::ERR_TRUNCATED};

	// in-bench parser phases
	localparam logic [3:0] S_ARRAY_MARK = 4'd0;
	localparam logic [3:0] S_COUNT      = 4'd1;
	localparam logic [3:0] S_COUNT_LF   = 4'd2;
	localparam logic [3:0] S_BULK_MARK  = 4'd3;
	localparam logic [3:0] S_LENGTH     = 4'd4;
	localparam logic [3:0] S_LENGTH_LF  = 4'd5;
	localparam logic [3:0] S_DATA       = 4'd6;
	localparam logic [3:0] S_SKIP1      = 4'd7;
	localparam logic [3:0] S_SKIP2      = 4'd8;
	localparam logic [3:0] S_IGNORE     = 4'd9;

	typedef struct packed {
		logic [7:0]          b;
		logic                eob;
		logic                typed;
		rasp_pkg::out_item_t want;
	} dir_row_t;

	logic                                clk;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_stall;
	rasp_pkg::in_item_t                  in_data   = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	rasp_pkg::out_item_t                 out_data;
	logic                                cfg_wen   = 1'b0;
	logic [rasp_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [rasp_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// in-bench parser state and its copy of the limit registers
	logic [3:0]   parse_phase;
	logic [63:0]  num_acc;
	logic         seen_digit;
	logic [31:0]  elems_left;
	logic [31:0]  cur_elem;
	logic [31:0]  decl_count;
	logic [63:0]  pay_left;
	logic [15:0]  lim_count;
	logic [29:0]  lim_length;

	rasp_pkg::out_item_t pending_results[$];
	logic [7:0]          frame_bytes[$];

	int unsigned  send_idle_pct    = IDLE_PCT;
	int unsigned  recv_idle_pct    = IDLE_PCT;
	int unsigned  holdoff_requests = 0;
	int unsigned  quiet_cycles     = 0;
	int unsigned  mismatches       = 0;
	int unsigned  beats_sent       = 0;
	int unsigned  buffers_sent     = 0;
	int unsigned  results_checked  = 0;
	int unsigned  seen_payload     = 0;
	int unsigned  seen_done        = 0;
	int unsigned  seen_error       = 0;
	logic [7:0]   fault_kinds_seen = '0;

	dir_row_t directed_rows [29] = '{
		// zero count: done comes on the line feed
		'{rasp_pkg::CH_STAR,           1'b0, 1'b1, R_NONE},
		'{rasp_pkg::CH_ZERO,           1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_CR,             1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_LF,             1'b1, 1'b1, R_DONE_EMPTY},
		// empty bulk string, then the buffer ends inside the next payload
		'{rasp_pkg::CH_STAR,           1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_ZERO + 8'd2,    1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_CR,             1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_LF,             1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_DOLLAR,         1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_ZERO,           1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_CR,             1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_LF,             1'b0, 1'b0, R_NONE},
		'{8'h00,                       1'b0, 1'b0, R_NONE},
		'{8'hFF,                       1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_DOLLAR,         1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_ZERO + 8'd1,    1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_CR,             1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_LF,             1'b0, 1'b0, R_NONE},
		'{8'hFF,                       1'b1, 1'b1, R_TRUNCATED},
		// wrong lead byte
		'{8'h00,                       1'b1, 1'b1, R_NOT_ARRAY},
		// sign in the count
		'{rasp_pkg::CH_STAR,           1'b0, 1'b0, R_NONE},
		'{CH_MINUS,                    1'b1, 1'b1, R_BAD_NUMBER},
		// count with no digits
		'{rasp_pkg::CH_STAR,           1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_CR,             1'b1, 1'b1, R_BAD_NUMBER},
		// count over the reset limit, caught on its fourth digit
		'{rasp_pkg::CH_STAR,           1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_ZERO + 8'd2,    1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_ZERO,           1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_ZERO,           1'b0, 1'b0, R_NONE},
		'{rasp_pkg::CH_ZERO,           1'b1, 1'b1, R_TOO_LARGE}
	};

	resp_array_stream_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic chance(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// parser back to its idle state, limits untouched
	function automatic void parser_rearm();
		parse_phase = S_ARRAY_MARK;
		num_acc     = '0;
		seen_digit  = 1'b0;
		elems_left  = '0;
		cur_elem    = '0;
		decl_count  = '0;
		pay_left    = '0;
	endfunction

	// one byte of a decimal number; error code, or none with at_cr on the CR
	function automatic logic [2:0] number_step(input logic [7:0] b, input logic [63:0] limit,
			output logic at_cr);
		at_cr = 1'b0;
		if (b == rasp_pkg::CH_CR) begin
			if (!seen_digit)
				return rasp_pkg::ERR_BAD_NUMBER;
			at_cr = 1'b1;
			return rasp_pkg::ERR_NONE;
		end
		if (b < rasp_pkg::CH_ZERO || b > rasp_pkg::CH_NINE)
			return rasp_pkg::ERR_BAD_NUMBER;
		num_acc    = num_acc * 64'd10 + 64'(b - rasp_pkg::CH_ZERO);
		seen_digit = 1'b1;
		if (num_acc > limit)
			return rasp_pkg::ERR_TOO_LARGE;
		return rasp_pkg::ERR_NONE;
	endfunction

	// expected result of one byte beat, advancing the parser state
	function automatic rasp_pkg::out_item_t parse_byte(input rasp_pkg::in_item_t it);
		rasp_pkg::out_item_t r;
		logic [2:0]          code;
		logic                at_cr;
		r = '0;
		unique case (parse_phase) inside
			S_ARRAY_MARK: begin
				if (it.in_byte == rasp_pkg::CH_STAR) begin
					parse_phase = S_COUNT;
					num_acc     = '0;
					seen_digit  = 1'b0;
				end else begin
					r.event_res  = rasp_pkg::EV_ERROR;
					r.fault_code = rasp_pkg::ERR_NOT_ARRAY;
					parse_phase  = S_IGNORE;
				end
			end
			S_COUNT, S_LENGTH: begin
				code = number_step(it.in_byte,
					(parse_phase == S_COUNT) ? 64'(lim_count) : 64'(lim_length), at_cr);
				if (code != rasp_pkg::ERR_NONE) begin
					r.event_res  = rasp_pkg::EV_ERROR;
					r.fault_code = code;
					parse_phase  = S_IGNORE;
				end else if (at_cr) begin
					parse_phase = (parse_phase == S_COUNT) ? S_COUNT_LF : S_LENGTH_LF;
				end
			end
			S_COUNT_LF: begin
				if (it.in_byte != rasp_pkg::CH_LF) begin
					r.event_res  = rasp_pkg::EV_ERROR;
					r.fault_code = rasp_pkg::ERR_BAD_NUMBER;
					parse_phase  = S_IGNORE;
				end else begin
					decl_count = num_acc[31:0];
					elems_left = decl_count;
					cur_elem   = '0;
					if (decl_count == 0) begin
						r.event_res = rasp_pkg::EV_DONE;
						parse_phase = S_IGNORE;
					end else begin
						parse_phase = S_BULK_MARK;
					end
				end
			end
			S_BULK_MARK: begin
				if (it.in_byte == rasp_pkg::CH_DOLLAR) begin
					parse_phase = S_LENGTH;
					num_acc     = '0;
					seen_digit  = 1'b0;
				end else begin
					r.event_res  = rasp_pkg::EV_ERROR;
					r.fault_code = rasp_pkg::ERR_EXP_BULK;
					parse_phase  = S_IGNORE;
				end
			end
			S_LENGTH_LF: begin
				if (it.in_byte != rasp_pkg::CH_LF) begin
					r.event_res  = rasp_pkg::EV_ERROR;
					r.fault_code = rasp_pkg::ERR_BAD_NUMBER;
					parse_phase  = S_IGNORE;
				end else begin
					pay_left    = num_acc;
					parse_phase = (pay_left == 0) ? S_SKIP1 : S_DATA;
				end
			end
			S_DATA: begin
				r.event_res       = rasp_pkg::EV_PAYLOAD;
				r.payload_byte    = it.in_byte;
				r.element_index   = cur_elem[15:0];
				r.last_of_element = (pay_left == 64'd1);
				pay_left          = pay_left - 64'd1;
				if (pay_left == 0)
					parse_phase = S_SKIP1;
			end
			S_SKIP1: parse_phase = S_SKIP2;
			S_SKIP2: begin
				elems_left = elems_left - 32'd1;
				cur_elem   = cur_elem + 32'd1;
				if (elems_left == 0) begin
					r.event_res     = rasp_pkg::EV_DONE;
					r.element_total = decl_count[15:0];
					parse_phase     = S_IGNORE;
				end else begin
					parse_phase = S_BULK_MARK;
				end
			end
			default: parse_phase = S_IGNORE;
		endcase
		// end of buffer: a parse still open is truncated, then re-arm
		if (it.end_of_buffer) begin
			if (r.event_res != rasp_pkg::EV_DONE && r.event_res != rasp_pkg::EV_ERROR
			    && parse_phase != S_IGNORE) begin
				r            = '0;
				r.event_res  = rasp_pkg::EV_ERROR;
				r.fault_code = rasp_pkg::ERR_TRUNCATED;
			end
			parser_rearm();
		end
		return r;
	endfunction

	// both limit registers, written back to back while the parser is idle
	task automatic set_limits(input logic [15:0] cnt, input logic [29:0] len);
		cfg_wen   <= 1'b1;
		cfg_index <= rasp_pkg::CFG_MAX_COUNT;
		cfg_data  <= rasp_pkg::CFG_DATA_BITS'(cnt);
		@(posedge clk);
		cfg_index <= rasp_pkg::CFG_MAX_LENGTH;
		cfg_data  <= rasp_pkg::CFG_DATA_BITS'(len);
		@(posedge clk);
		cfg_wen    <= 1'b0;
		lim_count  = cnt;
		lim_length = len;
	endtask

	// offer one byte beat, with a random gap first, and log its expected result
	task automatic send_beat(input rasp_pkg::in_item_t it, input logic typed,
			input rasp_pkg::out_item_t want);
		rasp_pkg::out_item_t predicted;
		if (chance(send_idle_pct)) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (chance(send_idle_pct));
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		predicted = parse_byte(it);
		pending_results = {pending_results, (typed ? want : predicted)};
		beats_sent++;
	endtask

	task automatic send_frame();
		rasp_pkg::in_item_t it;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			it.in_byte       = frame_bytes[i];
			it.end_of_buffer = (i == frame_bytes.size() - 1);
			send_beat(it, 1'b0, R_NONE);
		end
		frame_bytes.delete();
		buffers_sent++;
	endtask

	// hold the input quiet until every result beat is back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic void append_number(input logic [63:0] v, input int unsigned zeros);
		logic [7:0]  digits[$];
		logic [63:0] rest;
		rest = v;
		do begin
			digits.push_front(rasp_pkg::CH_ZERO + 8'(rest % 64'd10));
			rest = rest / 64'd10;
		end while (rest != 0);
		repeat (zeros) frame_bytes = {frame_bytes, rasp_pkg::CH_ZERO};
		frame_bytes = {frame_bytes, digits};
	endfunction

	function automatic int unsigned some_zeros();
		return chance(10) ? $urandom_range(1, 2) : 0;
	endfunction

	// a count or length: mostly small and legal, sometimes at or over the limit
	function automatic logic [63:0] pick_size(input logic [63:0] limit, input int unsigned cap);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return limit + 64'd1;
		if (r < 9 && limit <= cap)
			return limit;
		if (r < 11)
			return {$urandom, $urandom};
		return $urandom_range(0, (limit < cap) ? int'(limit) : cap);
	endfunction

	// a request buffer that is well formed up to any limit violation
	function automatic void build_request();
		logic [63:0] count;
		logic [63:0] len;
		frame_bytes = {frame_bytes, rasp_pkg::CH_STAR};
		count = pick_size(64'(lim_count), 4);
		append_number(count, some_zeros());
		if (count > lim_count) begin
			repeat ($urandom_range(0, 3)) frame_bytes = {frame_bytes, 8'($urandom)};
			return;
		end
		frame_bytes = {frame_bytes, rasp_pkg::CH_CR, rasp_pkg::CH_LF};
		for (int e = 0; e < int'(count); e++) begin
			frame_bytes = {frame_bytes, rasp_pkg::CH_DOLLAR};
			len = pick_size(64'(lim_length), chance(10) ? 40 : 6);
			append_number(len, some_zeros());
			if (len > lim_length) begin
				repeat ($urandom_range(0, 3)) frame_bytes = {frame_bytes, 8'($urandom)};
				return;
			end
			frame_bytes = {frame_bytes, rasp_pkg::CH_CR, rasp_pkg::CH_LF};
			repeat (int'(len)) frame_bytes = {frame_bytes, 8'($urandom)};
			frame_bytes = {frame_bytes, 8'($urandom), 8'($urandom)};
		end
		// junk after done is dropped up to the end of the buffer
		if (chance(20))
			repeat ($urandom_range(1, 3)) frame_bytes = {frame_bytes, 8'($urandom)};
	endfunction

	// corrupt, cut short or replace a request
	function automatic void damage_request();
		int unsigned pos;
		pos = $urandom_range(0, frame_bytes.size() - 1);
		case ($urandom_range(0, 3))
			0: frame_bytes[pos] = 8'($urandom);
			1: begin
				case ($urandom_range(0, 6))
					0: frame_bytes[pos] = rasp_pkg::CH_CR;
					1: frame_bytes[pos] = rasp_pkg::CH_LF;
					2: frame_bytes[pos] = CH_MINUS;
					3: frame_bytes[pos] = CH_PLUS;
					4: frame_bytes[pos] = rasp_pkg::CH_STAR;
					5: frame_bytes[pos] = rasp_pkg::CH_DOLLAR;
					default: frame_bytes[pos] = CH_SPACE;
				endcase
			end
			2: while (frame_bytes.size() > pos + 1) void'(frame_bytes.pop_back());
			default: begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 6)) frame_bytes = {frame_bytes, 8'($urandom)};
				if (chance(50))
					frame_bytes[0] = rasp_pkg::CH_STAR;
			end
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	function automatic void check_result(input rasp_pkg::out_item_t got);
		rasp_pkg::out_item_t want;
		if (pending_results.size() == 0) begin
			$error("result beat with no byte waiting for it: %h", got);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
		compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
		compare_field("element_index", 32'(want.element_index), 32'(got.element_index));
		compare_field("last_of_element", 32'(want.last_of_element),
			32'(got.last_of_element));
		compare_field("element_total", 32'(want.element_total), 32'(got.element_total));
		compare_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
		results_checked++;
		case (want.event_res)
			rasp_pkg::EV_PAYLOAD: seen_payload++;
			rasp_pkg::EV_DONE:    seen_done++;
			rasp_pkg::EV_ERROR: begin
				seen_error++;
				fault_kinds_seen[want.fault_code] = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// result beat check and count of cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// receiver: random stall, plus a long hold-off on request
	initial begin : receiver
		int unsigned holds_served;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (holdoff_requests != holds_served) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			out_stall <= chance(recv_idle_pct);
		end
	end

	// watchdog
	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$error("no beat moved for %0d cycles, %0d results outstanding", quiet_cycles,
			pending_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : main_seq
		int unsigned phase_start;
		lim_count  = rasp_pkg::MAX_COUNT_RST;
		lim_length = rasp_pkg::MAX_LENGTH_RST;
		parser_rearm();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-picked bytes first
		foreach (directed_rows[i])
			send_beat({directed_rows[i].b, directed_rows[i].eob}, directed_rows[i].typed,
				directed_rows[i].want);
		wait_for_results();

		// random requests under each limit setting
		for (int p = 0; p < 6; p++) begin
			case (p)
				1: set_limits(16'd3, 30'd5);
				2: set_limits(16'd0, 30'd0);
				3: set_limits(16'hFFFF, 30'h3FFF_FFFF);
				4: set_limits(16'($urandom_range(1, 6)), 30'($urandom_range(1, 12)));
				5: set_limits(rasp_pkg::MAX_COUNT_RST, rasp_pkg::MAX_LENGTH_RST);
				default: ;
			endcase
			// no idling at all while the widest limits are in force
			send_idle_pct = (p == 3) ? 0 : IDLE_PCT;
			recv_idle_pct <= (p == 3) ? 0 : IDLE_PCT;
			// long receiver hold-off so the input backs up
			if (p == 1)
				holdoff_requests <= holdoff_requests + 1;
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_ITEMS) begin
				build_request();
				if (chance(25))
					damage_request();
				send_frame();
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end
		$display("run covered %0d byte beats in %0d buffers under six limit settings",
			beats_sent, buffers_sent);
		$display("checked %0d results: %0d payload, %0d done, %0d error (codes seen %b)",
			results_checked, seen_payload, seen_done, seen_error, fault_kinds_seen);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
